// ===== hw/rtl/activity_selection_scheduler_macros.svh =====
// Assertion macros used by the scheduler datapath.
`ifndef ACTIVITY_SELECTION_SCHEDULER_MACROS_SVH
`define ACTIVITY_SELECTION_SCHEDULER_MACROS_SVH

// Check that an expression holds on every clock edge outside reset.
`define ASEL_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: invariant violated");

// Check that a condition implies another in the same cycle.
`define ASEL_ASSERT_IMPLIES(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("%m: implication violated");

// Check that a condition implies another in the following cycle.
`define ASEL_ASSERT_NEXT(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("%m: next-cycle check violated");

`endif

// ===== hw/rtl/asel_pkg.sv =====
// Shared types and constants of the activity selection scheduler.
`default_nettype none

package asel_pkg;

   localparam int TIME_W           = 16;
   localparam int INDEX_W          = 7;
   localparam int DEF_MAX_MEETINGS = 64;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PASS,
      ST_DECIDE
   } asel_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic store;
      logic pass_init;
      logic pass_step;
      logic take_best;
      logic emit;
      logic final_flag;
      logic finish;
   } asel_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic pass_done;
      logic found;
      logic have_pend;
      logic out_free;
   } asel_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/asel_if.sv =====
// Valid/ready channel interfaces for meeting and pick items.
`default_nettype none

interface asel_req_if;
   logic                        valid;
   logic                        ready;
   logic [asel_pkg::TIME_W-1:0] start_time;
   logic [asel_pkg::TIME_W-1:0] end_time;
   logic                        last_item;

   modport source (output valid, output start_time, output end_time, output last_item,
                   input ready);
   modport sink   (input valid, input start_time, input end_time, input last_item,
                   output ready);
endinterface

interface asel_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [asel_pkg::INDEX_W-1:0] meeting_index;
   logic                         final_pick;
   logic                         overflowed;

   modport source (output valid, output meeting_index, output final_pick, output overflowed,
                   input ready);
   modport sink   (input valid, input meeting_index, input final_pick, input overflowed,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/asel_datapath.sv =====
// Datapath: meeting stores, selection scan and result register.
`default_nettype none
`include "activity_selection_scheduler_macros.svh"

module asel_datapath #(
   parameter int MAX_MEETINGS = asel_pkg::DEF_MAX_MEETINGS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire asel_pkg::asel_cmd_type      cmd,
   output      asel_pkg::asel_stat_type     stat,
   input  wire logic [asel_pkg::TIME_W-1:0] req_start_time,
   input  wire logic [asel_pkg::TIME_W-1:0] req_end_time,
   asel_rsp_if.source                       rsp_port
);
   import asel_pkg::*;

   localparam int IDX_W = (MAX_MEETINGS > 1) ? $clog2(MAX_MEETINGS) : 1;
   localparam int CNT_W = $clog2(MAX_MEETINGS + 1);

   // Meeting stores
   logic [TIME_W-1:0] start_mem [MAX_MEETINGS];
   logic [TIME_W-1:0] end_mem   [MAX_MEETINGS];

   // Fill state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              full;

   // Scan state
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic              rd_en;
   logic              tag_valid_ff, tag_valid_in;
   logic [IDX_W-1:0]  rd_slot_ff;
   logic [TIME_W-1:0] rd_start_ff, rd_end_ff;

   // Best candidate of the current pass
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_slot_ff;
   logic [TIME_W-1:0] best_end_ff;
   logic              qualify, better, take;

   // Pending pick, held until its final flag is known
   logic              have_pend_ff, have_pend_in;
   logic              first_ff, first_in;
   logic [IDX_W-1:0]  pend_slot_ff;
   logic [TIME_W-1:0] finish_limit_ff;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic               rsp_final_ff, rsp_ovf_ff;
   logic               out_free;

   assign full     = (count_ff >= CNT_W'(MAX_MEETINGS));
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   // Store an incoming meeting, flag it when the store is full
   always_ff @(posedge clock) begin
      if (cmd.store && !full) begin
         start_mem[count_ff[IDX_W-1:0]] <= req_start_time;
         end_mem[count_ff[IDX_W-1:0]]   <= req_end_time;
      end
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.finish) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (cmd.store) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // Sweep the stores one entry a cycle; rewind at each pass and at the end of a set
   assign rd_en = cmd.pass_step && (ptr_ff < count_ff);

   always_comb begin
      ptr_in       = ptr_ff;
      tag_valid_in = tag_valid_ff;
      if (cmd.pass_init || cmd.finish) begin
         ptr_in       = '0;
         tag_valid_in = 1'b0;
      end else if (cmd.pass_step) begin
         tag_valid_in = rd_en;
         if (rd_en) begin
            ptr_in = ptr_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_start_ff <= start_mem[ptr_ff[IDX_W-1:0]];
         rd_end_ff   <= end_mem[ptr_ff[IDX_W-1:0]];
         rd_slot_ff  <= ptr_ff[IDX_W-1:0];
      end
   end

   // Candidate must follow the pending pick in end-time order and start no earlier than it ends
   assign qualify = first_ff ||
                    ((rd_start_ff >= finish_limit_ff) &&
                     ({rd_end_ff, rd_slot_ff} > {finish_limit_ff, pend_slot_ff}));
   assign better  = !found_ff || ({rd_end_ff, rd_slot_ff} < {best_end_ff, best_slot_ff});
   assign take    = tag_valid_ff && qualify && better;

   always_comb begin
      found_in = found_ff;
      if (cmd.pass_init) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_slot_ff <= rd_slot_ff;
         best_end_ff  <= rd_end_ff;
      end
   end

   // Promote the best candidate to the pending pick
   always_comb begin
      have_pend_in = have_pend_ff;
      first_in     = first_ff;
      if (cmd.finish) begin
         have_pend_in = 1'b0;
         first_in     = 1'b1;
      end else if (cmd.take_best) begin
         have_pend_in = 1'b1;
         first_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_best) begin
         pend_slot_ff <= best_slot_ff;
      end
   end

   // Load the result register from the pending pick
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_index_ff <= INDEX_W'(pend_slot_ff) + INDEX_W'(1);
         rsp_final_ff <= cmd.final_flag;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         ovf_ff          <= 1'b0;
         ptr_ff          <= '0;
         tag_valid_ff    <= 1'b0;
         found_ff        <= 1'b0;
         have_pend_ff    <= 1'b0;
         first_ff        <= 1'b1;
         finish_limit_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         ptr_ff       <= ptr_in;
         tag_valid_ff <= tag_valid_in;
         found_ff     <= found_in;
         have_pend_ff <= have_pend_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.take_best) begin
            finish_limit_ff <= best_end_ff;
         end
      end
   end

   assign stat.pass_done = (ptr_ff == count_ff) && !tag_valid_ff;
   assign stat.found     = found_ff;
   assign stat.have_pend = have_pend_ff;
   assign stat.out_free  = out_free;

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.meeting_index = rsp_index_ff;
   assign rsp_port.final_pick    = rsp_final_ff;
   assign rsp_port.overflowed    = rsp_ovf_ff;

   `ASEL_ASSERT_ALWAYS(a_count_in_range, clock, reset, count_ff <= CNT_W'(MAX_MEETINGS))
   `ASEL_ASSERT_ALWAYS(a_ptr_in_range, clock, reset, ptr_ff <= count_ff)
   `ASEL_ASSERT_IMPLIES(a_emit_no_overwrite, clock, reset, cmd.emit, out_free && have_pend_ff)
   `ASEL_ASSERT_NEXT(a_finish_clears, clock, reset, cmd.finish, count_ff == '0 && !ovf_ff)

endmodule

`default_nettype wire

// ===== hw/rtl/asel_controller.sv =====
// Controller: sequences loading, selection passes and result hand-off.
`default_nettype none

module asel_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_last_item,
   output      logic                    req_ready,
   input  wire asel_pkg::asel_stat_type stat,
   output      asel_pkg::asel_cmd_type  cmd
);
   import asel_pkg::*;

   asel_state_type state_ff, state_in;
   logic           accept;

   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_last_item) begin
               state_in = ST_PASS;
            end
         end
         ST_PASS: begin
            if (stat.pass_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (stat.found) begin
               if (!stat.have_pend || stat.out_free) begin
                  state_in = ST_PASS;
               end
            end else if (stat.out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_LOAD: begin
            cmd.store     = accept;
            cmd.pass_init = accept && req_last_item;
         end
         ST_PASS: begin
            cmd.pass_step = 1'b1;
         end
         ST_DECIDE: begin
            if (stat.found) begin
               // Release the previous pick, then search after the new one
               if (!stat.have_pend || stat.out_free) begin
                  cmd.emit      = stat.have_pend;
                  cmd.take_best = 1'b1;
                  cmd.pass_init = 1'b1;
               end
            end else if (stat.out_free) begin
               // Nothing follows: the pending pick is the last one
               cmd.emit       = 1'b1;
               cmd.final_flag = 1'b1;
               cmd.finish     = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/activity_selection_scheduler.sv =====
// Loading takes one meeting item per cycle. After the last item, selection runs
// picks + 1 passes over the n stored meetings, each a sweep of store reads
// followed by a decision. Each pick enters the result register at the decision
// that ends the pass after the one that found it, held back while the output
// stalls; input is taken again once the final pick is in the register.
// Synchronous active-high reset empties the set and the result register.
`default_nettype none

module activity_selection_scheduler #(
   parameter int MAX_MEETINGS = asel_pkg::DEF_MAX_MEETINGS
) (
   input wire logic  clock,
   input wire logic  reset,
   asel_req_if.sink  req_port,
   asel_rsp_if.source rsp_port
);
   import asel_pkg::*;

   asel_cmd_type  cmd;
   asel_stat_type stat;

   asel_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_port.valid),
      .req_last_item (req_port.last_item),
      .req_ready     (req_port.ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   asel_datapath #(
      .MAX_MEETINGS (MAX_MEETINGS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_start_time (req_port.start_time),
      .req_end_time   (req_port.end_time),
      .rsp_port       (rsp_port)
   );

endmodule

`default_nettype wire

// ===== sim/tb_activity_selection_scheduler.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the activity selection scheduler: directed table, then random sets.
module tb_activity_selection_scheduler;
   import asel_pkg::*;

   localparam int CAPACITY      = DEF_MAX_MEETINGS;
   localparam int ITEM_TARGET   = 380;
   localparam int TAIL_START    = 330;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int RUN_LIMIT_NS  = 8_000_000;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIRECTED_ROWS = 22;

   typedef struct packed {
      logic [INDEX_W-1:0] meeting_index;
      logic               final_pick;
      logic               overflowed;
   } pick_type;

   // typed_n: 0 = use the predictor, 1 or 2 = picks typed in below
   typedef struct packed {
      logic [TIME_W-1:0]  t_start;
      logic [TIME_W-1:0]  t_end;
      logic               last_flag;
      logic [1:0]         typed_n;
      logic [INDEX_W-1:0] typed_a;
      logic [INDEX_W-1:0] typed_b;
   } row_type;

   typedef enum logic [1:0] {
      SET_DENSE,
      SET_WIDE,
      SET_DISJOINT,
      SET_TIES
   } set_style_type;

   logic clock;
   logic reset;

   asel_req_if req_ch ();
   asel_rsp_if rsp_ch ();

   activity_selection_scheduler #(
      .MAX_MEETINGS(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_ch.sink),
      .rsp_port(rsp_ch.source)
   );

   // Room model: stored meetings and the picks still owed by the block
   logic [TIME_W-1:0] held_start [CAPACITY];
   logic [TIME_W-1:0] held_end [CAPACITY];
   int                held_count = 0;
   logic              held_overflow = 1'b0;
   logic [TIME_W-1:0] latest_end = '0;
   pick_type          set_picks [$];
   pick_type          pending_picks [$];

   int items_sent   = 0;
   int mismatches   = 0;
   int hold_asks    = 0;
   int holds_served = 0;
   bit quiet_tail   = 1'b0;

   row_type directed_rows [DIRECTED_ROWS] = '{
      // one meeting each: all zeros, all ones, end before start
      '{16'd0,     16'd0,     1'b1, 2'd1, 7'd1, 7'd0},
      '{16'd65535, 16'd65535, 1'b1, 2'd1, 7'd1, 7'd0},
      '{16'd65535, 16'd0,     1'b1, 2'd1, 7'd1, 7'd0},
      // widest meeting first, zero-length one at time zero second
      '{16'd0,     16'd65535, 1'b0, 2'd0, 7'd0, 7'd0},
      '{16'd0,     16'd0,     1'b1, 2'd2, 7'd2, 7'd1},
      // equal end times: lower position wins
      '{16'd5,     16'd10,    1'b0, 2'd0, 7'd0, 7'd0},
      '{16'd0,     16'd10,    1'b0, 2'd0, 7'd0, 7'd0},
      '{16'd10,    16'd10,    1'b1, 2'd0, 7'd0, 7'd0},
      // textbook chain
      '{16'd1,     16'd2,     1'b0, 2'd0, 7'd0, 7'd0},
      '{16'd3,     16'd4,     1'b0, 2'd0, 7'd0, 7'd0},
      '{16'd0,     16'd6,     1'b0, 2'd0, 7'd0, 7'd0},
      '{16'd5,     16'd7,     1'b0, 2'd0, 7'd0, 7'd0},
      '{16'd8,     16'd9,     1'b0, 2'd0, 7'd0, 7'd0},
      '{16'd5,     16'd9,     1'b1, 2'd0, 7'd0, 7'd0},
      // fully nested meetings: only the innermost is taken
      '{16'd0,     16'd100,   1'b0, 2'd0, 7'd0, 7'd0},
      '{16'd10,    16'd90,    1'b0, 2'd0, 7'd0, 7'd0},
      '{16'd20,    16'd80,    1'b0, 2'd0, 7'd0, 7'd0},
      '{16'd30,    16'd70,    1'b1, 2'd0, 7'd0, 7'd0},
      // alternating bit patterns
      '{16'hAAAA,  16'h5555,  1'b0, 2'd0, 7'd0, 7'd0},
      '{16'h5555,  16'hAAAA,  1'b0, 2'd0, 7'd0, 7'd0},
      '{16'hFFFF,  16'hFFFF,  1'b0, 2'd0, 7'd0, 7'd0},
      '{16'h0000,  16'h0001,  1'b1, 2'd0, 7'd0, 7'd0}
   };

   // Append one pick at the tail of a pick queue
   function automatic void append_pick(ref pick_type q [$], input pick_type p);
      q.insert(q.size(), p);
   endfunction

   // Store one meeting; on the last one, work out the greedy picks into set_picks
   function automatic void schedule_meeting(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e,
                                            logic last);
      int       order [CAPACITY];
      int       i;
      int       j;
      int       key;
      pick_type p;
      set_picks.delete();
      if (held_count < CAPACITY) begin
         held_start[held_count] = s;
         held_end[held_count]   = e;
         held_count++;
      end else begin
         held_overflow = 1'b1;
      end
      if (!last) return;

      // stable insertion order by end time
      for (i = 0; i < held_count; i++) order[i] = i;
      for (i = 1; i < held_count; i++) begin
         key = order[i];
         j   = i;
         while (j > 0 && held_end[order[j-1]] > held_end[key]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = key;
      end

      // take the earliest finisher, then every meeting that starts no earlier than the last pick ends
      latest_end      = held_end[order[0]];
      p.meeting_index = INDEX_W'(order[0] + 1);
      p.final_pick    = 1'b0;
      p.overflowed    = held_overflow;
      append_pick(set_picks, p);
      for (i = 1; i < held_count; i++) begin
         if (held_start[order[i]] >= latest_end) begin
            p.meeting_index = INDEX_W'(order[i] + 1);
            append_pick(set_picks, p);
            latest_end = held_end[order[i]];
         end
      end
      p = set_picks.pop_back();
      p.final_pick = 1'b1;
      append_pick(set_picks, p);

      held_count    = 0;
      held_overflow = 1'b0;
   endfunction

   // Offer one meeting, wait for it to be taken, then queue the picks it causes and sometimes idle
   task automatic present_meeting(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
                                  input logic last, input logic [1:0] typed_n,
                                  input logic [INDEX_W-1:0] typed_a,
                                  input logic [INDEX_W-1:0] typed_b);
      pick_type p;
      req_ch.valid      <= 1'b1;
      req_ch.start_time <= s;
      req_ch.end_time   <= e;
      req_ch.last_item  <= last;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      schedule_meeting(s, e, last);

      // picks typed into the table replace the predicted ones
      if (typed_n != 2'd0) begin
         set_picks.delete();
         p.meeting_index = typed_a;
         p.final_pick    = (typed_n == 2'd1);
         p.overflowed    = 1'b0;
         append_pick(set_picks, p);
         if (typed_n == 2'd2) begin
            p.meeting_index = typed_b;
            p.final_pick    = 1'b1;
            append_pick(set_picks, p);
         end
      end
      foreach (set_picks[k]) append_pick(pending_picks, set_picks[k]);

      // idle burst with junk on the payload
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_ch.valid      <= 1'b0;
         req_ch.start_time <= TIME_W'($urandom_range(0, 65535));
         req_ch.end_time   <= TIME_W'($urandom_range(0, 65535));
         req_ch.last_item  <= 1'($urandom_range(0, 1));
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Hold the input until every owed pick has come back
   task automatic await_all_picks();
      req_ch.valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Send one set of meetings; the last one closes the set
   task automatic run_set(input int size, input set_style_type style);
      int slot_rank [CAPACITY+8];
      int k;
      int swap_at;
      int tmp;
      int s_i;
      int e_i;
      for (k = 0; k < size; k++) slot_rank[k] = k;
      for (k = size - 1; k > 0; k--) begin
         swap_at          = $urandom_range(0, k);
         tmp              = slot_rank[k];
         slot_rank[k]     = slot_rank[swap_at];
         slot_rank[swap_at] = tmp;
      end
      for (k = 0; k < size; k++) begin
         case (style)
            SET_DENSE: begin
               s_i = $urandom_range(0, 400);
               if ($urandom_range(0, 9) == 0) e_i = $urandom_range(0, s_i);
               else e_i = s_i + $urandom_range(0, 60);
            end
            SET_TIES: begin
               s_i = $urandom_range(0, 12) * 5;
               e_i = s_i + $urandom_range(0, 2) * 5;
            end
            SET_DISJOINT: begin
               // one time window per meeting, shuffled so every stored meeting is picked
               s_i = slot_rank[k] * 930 + $urandom_range(0, 300);
               e_i = slot_rank[k] * 930 + $urandom_range(400, 900);
            end
            default: begin
               s_i = $urandom_range(0, 65535);
               e_i = $urandom_range(0, 65535);
            end
         endcase
         present_meeting(TIME_W'(s_i), TIME_W'(e_i), k == size - 1, 2'd0, '0, '0);
      end
   endtask

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Meeting source: directed table, random sets, then drain and verdict
   initial begin : meeting_source
      int            r;
      int            set_no;
      int            size;
      set_style_type style;
      row_type       row;
      req_ch.valid      <= 1'b0;
      req_ch.start_time <= '0;
      req_ch.end_time   <= '0;
      req_ch.last_item  <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);

      for (r = 0; r < DIRECTED_ROWS; r++) begin
         row = directed_rows[r];
         present_meeting(row.t_start, row.t_end, row.last_flag, row.typed_n, row.typed_a,
                         row.typed_b);
      end

      set_no = 0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= TAIL_START) quiet_tail = 1'b1;
         // pause the input until the block has answered everything
         if (set_no == 14) await_all_picks();
         case (set_no)
            2: run_set(CAPACITY, SET_DISJOINT);
            5: begin
               run_set(10, SET_DENSE);
               // keep the result side stalled while the next set is offered
               hold_asks++;
            end
            8:  run_set(CAPACITY + 1, SET_DISJOINT);
            11: run_set(CAPACITY + 6, SET_WIDE);
            default: begin
               r = $urandom_range(0, 19);
               if (r < 10) style = SET_DENSE;
               else if (r < 14) style = SET_TIES;
               else if (r < 17) style = SET_DISJOINT;
               else style = SET_WIDE;
               if ($urandom_range(0, 7) == 0) size = $urandom_range(11, 30);
               else size = $urandom_range(1, 10);
               run_set(size, style);
            end
         endcase
         set_no++;
      end

      await_all_picks();
      if (mismatches == 0 && pending_picks.size() == 0) begin
         $display("activity_selection_scheduler regression: pass");
      end else begin
         $display("activity_selection_scheduler regression: fail");
      end
      $finish;
   end

   // Pick sink: check each accepted pick, then choose next cycle's ready
   initial begin : pick_sink
      int       stall_left;
      pick_type got;
      pick_type want;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.meeting_index = rsp_ch.meeting_index;
            got.final_pick    = rsp_ch.final_pick;
            got.overflowed    = rsp_ch.overflowed;
            if (pending_picks.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected pick: index %0d final %0b overflow %0b",
                           got.meeting_index, got.final_pick, got.overflowed);
            end else begin
               want = pending_picks.pop_front();
               if (got.meeting_index !== want.meeting_index ||
                   got.final_pick !== want.final_pick ||
                   got.overflowed !== want.overflowed) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("pick mismatch: expected index %0d final %0b overflow %0b, %s",
                              want.meeting_index, want.final_pick, want.overflowed,
                              $sformatf("got index %0d final %0b overflow %0b",
                                        got.meeting_index, got.final_pick, got.overflowed));
               end
            end
         end

         // long hold on request, otherwise short random stall bursts
         if (hold_asks != holds_served) begin
            holds_served++;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("activity_selection_scheduler regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/asel_pkg.sv
hw/rtl/asel_if.sv
hw/rtl/asel_datapath.sv
hw/rtl/asel_controller.sv
hw/rtl/activity_selection_scheduler.sv
sim/tb_activity_selection_scheduler.sv
